[hw/rtl/tdce_pkg.sv]
// ----------------------------------------------------------------------------
// tdce_pkg
// Shared constants, codes and controller/datapath signal groups for the
// torus degree-capped edge selector.
// ----------------------------------------------------------------------------
package tdce_pkg;

  localparam int SIDE_MAX_DEF = 64;

  localparam int EDGE_W     = 13;
  localparam int TYPE_W     = 2;
  localparam int COUNT_W    = 13;
  localparam int NODE_CNT_W = 3;
  localparam int SIDE_W     = 7;
  localparam int TARGET_W   = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = SIDE_W;

  localparam logic [SIDE_W-1:0]   SIDE_RST   = 7'd64;
  localparam logic [TARGET_W-1:0] TARGET_RST = 3'd2;

  localparam logic [TYPE_W-1:0] TYPE_ONE = 2'd1;
  localparam logic [TYPE_W-1:0] TYPE_TWO = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_SIDE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET = 1'd1;

  typedef struct packed {
    logic load;
    logic prep;
    logic div_step;
    logic rd1;
    logic rd2;
    logic judge;
    logic wr2;
    logic sweep;
    logic scan_count;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic div_end;
    logic sweep_end;
    logic last;
    logic out_free;
  } status_t;

endpackage

[hw/rtl/tdce_if.sv]
// ----------------------------------------------------------------------------
// tdce_if
// Valid/ready channels for edge items and result items.
// ----------------------------------------------------------------------------
interface tdce_in_if;
  logic                        valid;
  logic                        ready;
  logic [tdce_pkg::EDGE_W-1:0] edge_index;
  logic                        last_edge;

  modport source (output valid, edge_index, last_edge, input ready);
  modport sink (input valid, edge_index, last_edge, output ready);
endinterface

interface tdce_out_if;
  logic                         valid;
  logic                         ready;
  logic [tdce_pkg::EDGE_W-1:0]  edge_echo;
  logic [tdce_pkg::TYPE_W-1:0]  edge_type;
  logic                         index_error;
  logic                         run_done;
  logic [tdce_pkg::COUNT_W-1:0] unsatisfied_count;

  modport source (output valid, edge_echo, edge_type, index_error, run_done,
                  unsatisfied_count, input ready);
  modport sink (input valid, edge_echo, edge_type, index_error, run_done,
                unsatisfied_count, output ready);
endinterface

[hw/rtl/torus_degree_capped_edge_select.sv]
// ----------------------------------------------------------------------------
// torus_degree_capped_edge_select
// Greedy degree-capped edge marking on a square torus with end-of-run scan.
//
//   channel   | dir | handshake          | payload
//   ----------+-----+--------------------+-------------------------------------
//   edges     | in  | valid/ready        | edge_index, last_edge
//   results   | out | valid/ready        | edge_echo, edge_type, index_error,
//             |     |                    | run_done, unsatisfied_count
//   wr_*      | in  | wr_en              | wr_index, wr_data
//
// An edge is divided one remainder bit per cycle, then takes two counter
// reads and two writes on the one-read one-write counter memory. A last
// edge adds a node scan. After reset a clearing pass over all
// SIDE_MAX*SIDE_MAX counters runs before the first edge is taken. A stalled
// result waits in the output register while the next edge is processed;
// that edge holds its result until it drains.
// ----------------------------------------------------------------------------
module torus_degree_capped_edge_select #(
  parameter int SIDE_MAX = tdce_pkg::SIDE_MAX_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  tdce_in_if.sink                             edges,
  tdce_out_if.source                          results,
  input  logic                                wr_en,
  input  logic [tdce_pkg::CFG_IDX_W-1:0]      wr_index,
  input  logic [tdce_pkg::CFG_DATA_W-1:0]     wr_data
);
  import tdce_pkg::*;

  logic [SIDE_W-1:0]   side_length;
  logic [TARGET_W-1:0] target_per_node;
  cmd_t                cmd;
  status_t             status;

  always_ff @(posedge clk) begin
    if (rst) begin
      side_length     <= SIDE_RST;
      target_per_node <= TARGET_RST;
    end else if (wr_en) begin
      case (wr_index)
        REG_SIDE:   side_length     <= wr_data;
        REG_TARGET: target_per_node <= wr_data[TARGET_W-1:0];
        default: ;
      endcase
    end
  end

  tdce_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (edges.valid),
    .in_ready (edges.ready),
    .status   (status),
    .cmd      (cmd)
  );

  tdce_dp #(
    .SIDE_MAX (SIDE_MAX)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .status            (status),
    .edge_index        (edges.edge_index),
    .last_edge         (edges.last_edge),
    .side_length       (side_length),
    .target_per_node   (target_per_node),
    .out_valid         (results.valid),
    .out_ready         (results.ready),
    .edge_echo         (results.edge_echo),
    .edge_type         (results.edge_type),
    .index_error       (results.index_error),
    .run_done          (results.run_done),
    .unsatisfied_count (results.unsatisfied_count)
  );

endmodule

[hw/rtl/tdce_ram.sv]
// ----------------------------------------------------------------------------
// tdce_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tdce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/tdce_ctrl.sv]
// ----------------------------------------------------------------------------
// tdce_ctrl
// Sequencer: clearing pass, per-edge division and counter update, node scan.
// ----------------------------------------------------------------------------
module tdce_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  tdce_pkg::status_t status,
  output tdce_pkg::cmd_t    cmd
);
  import tdce_pkg::*;

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_PREP   = 4'd2;
  localparam logic [3:0] S_DIV    = 4'd3;
  localparam logic [3:0] S_RD1    = 4'd4;
  localparam logic [3:0] S_RD2    = 4'd5;
  localparam logic [3:0] S_JUDGE  = 4'd6;
  localparam logic [3:0] S_WR2    = 4'd7;
  localparam logic [3:0] S_SCAN   = 4'd8;
  localparam logic [3:0] S_TAIL   = 4'd9;
  localparam logic [3:0] S_FINISH = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.sweep = 1'b1;
        if (status.sweep_end) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_end) state_next = S_RD1;
      end
      S_RD1: begin
        cmd.rd1    = 1'b1;
        state_next = S_RD2;
      end
      S_RD2: begin
        cmd.rd2    = 1'b1;
        state_next = S_JUDGE;
      end
      S_JUDGE: begin
        cmd.judge  = 1'b1;
        state_next = S_WR2;
      end
      S_WR2: begin
        cmd.wr2    = 1'b1;
        state_next = status.last ? S_SCAN : S_FINISH;
      end
      S_SCAN: begin
        cmd.sweep      = 1'b1;
        cmd.scan_count = 1'b1;
        if (status.sweep_end) state_next = S_TAIL;
      end
      S_TAIL: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[hw/rtl/tdce_dp.sv]
// ----------------------------------------------------------------------------
// tdce_dp
// Datapath: endpoint addressing, shift-subtract remainder, node counter
// memory, scan counter and result register.
// ----------------------------------------------------------------------------
module tdce_dp #(
  parameter int SIDE_MAX = tdce_pkg::SIDE_MAX_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  tdce_pkg::cmd_t                  cmd,
  output tdce_pkg::status_t               status,
  input  logic [tdce_pkg::EDGE_W-1:0]     edge_index,
  input  logic                            last_edge,
  input  logic [tdce_pkg::SIDE_W-1:0]     side_length,
  input  logic [tdce_pkg::TARGET_W-1:0]   target_per_node,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [tdce_pkg::EDGE_W-1:0]     edge_echo,
  output logic [tdce_pkg::TYPE_W-1:0]     edge_type,
  output logic                            index_error,
  output logic                            run_done,
  output logic [tdce_pkg::COUNT_W-1:0]    unsatisfied_count
);
  import tdce_pkg::*;

  localparam int NODE_MAX = SIDE_MAX * SIDE_MAX;
  localparam int NAW      = $clog2(NODE_MAX);
  localparam int NNW      = $clog2(NODE_MAX + 1);
  localparam int LW       = $clog2(SIDE_MAX + 1);
  localparam int QW       = $clog2(SIDE_MAX);
  localparam int BW       = $clog2(QW + 1);
  localparam int CW       = (NNW + 1 > EDGE_W) ? NNW + 1 : EDGE_W;
  localparam int SW       = (LW > SIDE_W) ? LW : SIDE_W;

  logic [EDGE_W-1:0]     e_r;
  logic                  last_r;
  logic [LW-1:0]         l_r;
  logic [NNW-1:0]        nn_r;
  logic                  err_r;
  logic                  horiz_r;
  logic [CW-1:0]         v_r;
  logic [CW-1:0]         rem;
  logic [CW-1:0]         dsr;
  logic [BW-1:0]         dcnt;
  logic [NAW-1:0]        n2_r;
  logic [NODE_CNT_W-1:0] c1_r;
  logic [NODE_CNT_W-1:0] c2_r;
  logic                  ok_r;
  logic [NAW-1:0]        sweep_addr;
  logic [NAW-1:0]        addr_d;
  logic                  cnt_vld;
  logic [COUNT_W-1:0]    unsat;

  logic [SW-1:0]         side_ext;
  logic [LW-1:0]         l_c;
  logic [CW-1:0]         e_ext;
  logic [CW-1:0]         nn_ext;
  logic [CW-1:0]         l_ext;
  logic [CW-1:0]         n2_c;
  logic                  ok_c;
  logic                  sweep_end;

  logic                  ram_we;
  logic [NAW-1:0]        ram_waddr;
  logic [NODE_CNT_W-1:0] ram_wdata;
  logic [NAW-1:0]        ram_raddr;
  logic [NODE_CNT_W-1:0] ram_rdata;

  assign side_ext = SW'(side_length);
  always_comb begin
    if (side_ext < SW'(2)) begin
      l_c = LW'(2);
    end else if (side_ext > SW'(SIDE_MAX)) begin
      l_c = LW'(SIDE_MAX);
    end else begin
      l_c = side_ext[LW-1:0];
    end
  end

  assign e_ext  = CW'(e_r);
  assign nn_ext = CW'(nn_r);
  assign l_ext  = CW'(l_r);

  always_comb begin
    if (horiz_r) begin
      n2_c = (rem == l_ext - CW'(1)) ? v_r + CW'(1) - l_ext : v_r + CW'(1);
    end else begin
      n2_c = (v_r + l_ext >= nn_ext) ? v_r + l_ext - nn_ext : v_r + l_ext;
    end
  end

  assign ok_c = !err_r && (c1_r < target_per_node) && (ram_rdata < target_per_node);
  assign sweep_end = (sweep_addr == NAW'(NODE_MAX - 1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      e_r    <= edge_index;
      last_r <= last_edge;
      l_r    <= l_c;
      nn_r   <= NNW'(l_c) * NNW'(l_c);
    end
    if (cmd.prep) begin
      err_r   <= e_ext >= (nn_ext << 1);
      horiz_r <= e_ext < nn_ext;
      v_r     <= (e_ext < nn_ext) ? e_ext : e_ext - nn_ext;
      rem     <= (e_ext < nn_ext) ? e_ext : e_ext - nn_ext;
      dsr     <= l_ext << (QW - 1);
      dcnt    <= BW'(QW - 1);
    end
    if (cmd.div_step) begin
      if (rem >= dsr) rem <= rem - dsr;
      dsr  <= dsr >> 1;
      dcnt <= dcnt - BW'(1);
    end
    if (cmd.rd1) begin
      n2_r <= n2_c[NAW-1:0];
    end
    if (cmd.rd2) begin
      c1_r <= ram_rdata;
    end
    if (cmd.judge) begin
      c2_r <= ram_rdata;
      ok_r <= ok_c;
    end
    addr_d <= sweep_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_addr <= '0;
      cnt_vld    <= 1'b0;
      unsat      <= '0;
    end else begin
      if (cmd.sweep) begin
        sweep_addr <= sweep_end ? '0 : sweep_addr + NAW'(1);
      end
      cnt_vld <= cmd.sweep & cmd.scan_count;
      if (cmd.load) begin
        unsat <= '0;
      end else if (cnt_vld && (NNW'(addr_d) < nn_r) && (ram_rdata != target_per_node)) begin
        unsat <= unsat + COUNT_W'(1);
      end
    end
  end

  always_comb begin
    ram_raddr = v_r[NAW-1:0];
    ram_waddr = v_r[NAW-1:0];
    ram_wdata = c1_r + NODE_CNT_W'(1);
    ram_we    = cmd.judge & ok_c;
    if (cmd.sweep) begin
      ram_raddr = sweep_addr;
      ram_waddr = sweep_addr;
      ram_wdata = '0;
      ram_we    = 1'b1;
    end else if (cmd.rd2) begin
      ram_raddr = n2_r;
    end else if (cmd.wr2) begin
      ram_waddr = n2_r;
      ram_wdata = c2_r + NODE_CNT_W'(1);
      ram_we    = ok_r;
    end
  end

  tdce_ram #(
    .WIDTH (NODE_CNT_W),
    .DEPTH (NODE_MAX)
  ) u_counts (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      edge_echo         <= e_r;
      edge_type         <= ok_r ? TYPE_ONE : TYPE_TWO;
      index_error       <= err_r;
      run_done          <= last_r;
      unsatisfied_count <= unsat;
    end
  end

  assign status.div_end   = (dcnt == '0);
  assign status.sweep_end = sweep_end;
  assign status.last      = last_r;
  assign status.out_free  = !out_valid || out_ready;

  a_endpoints_differ: assert property (@(posedge clk) disable iff (rst)
    cmd.judge && ok_c |-> v_r[NAW-1:0] != n2_r)
    else $error("edge endpoints coincide");

  a_count_capped: assert property (@(posedge clk) disable iff (rst)
    ram_we && !cmd.sweep |-> ram_wdata <= target_per_node)
    else $error("node counter exceeds target");

  a_type_one_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && edge_type == TYPE_ONE |-> !index_error)
    else $error("type one on an out-of-range edge");

  a_unsat_only_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && !run_done |-> unsatisfied_count == '0)
    else $error("unsatisfied count outside run end");

endmodule
